// ----- hw/rtl/itcf_pkg.sv -----
// Shared types, constants and helper functions for the IMU tilt filter.
// Depends on nothing; every other file of the block imports it.
package itcf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int TAB_LEN         = 24;
    localparam int CORD_RUN        = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    localparam int ANG_W     = 32;   // angle word: degrees * 2^ANGLE_FRAC_BITS
    localparam int W_W       = 17;   // blend weight width
    localparam int SQ_W      = 53;   // square root operand width
    localparam int SQ_STEPS  = (SQ_W + 1) / 2;  // one root bit per step
    localparam int GQ_W      = 24;   // gyro increment quotient width
    localparam int CNT_W     = 6;
    localparam int CIDX_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(65536);

    // Gyro increment: (P * 2^16 + 131 * 2^15) / (131 * 2^16) == (P + 65) / 131.
    // P + 65 stays below 2^31, so a multiply by ceil(2^39 / 131) and a shift
    // by 39 gives the exact quotient.
    localparam logic [30:0] GYRO_HALF  = 31'd65;
    localparam logic [31:0] GYRO_RECIP = 32'd4196609267;
    localparam int          GYRO_SHIFT = 39;

    localparam logic signed [ANG_W-1:0] ANGLE_LIM = ANG_W'(180 <<< ANGLE_FRAC_BITS);
    localparam logic signed [15:0]      ONE_G     = 16'sd16384;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BLEND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BLEND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FUSION_WEIGHT = 2'd2;

    localparam logic [1:0] MIX_ACC  = 2'd0;
    localparam logic [1:0] MIX_GYR  = 2'd1;
    localparam logic [1:0] MIX_FUSE = 2'd2;

    typedef struct packed {
        logic              load;
        logic              prep;
        logic              init;
        logic              iter;
        logic              cload;
        logic              cstep;
        logic [CIDX_W-1:0] cidx;
        logic              mul;
        logic              sum;
        logic [1:0]        msel;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

    // atan(2^-i) in degrees * 2^16, rounded
    function automatic logic signed [ANG_W-1:0] atan_step(input logic [CIDX_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 32'sd2949120;
            5'd1:    v = 32'sd1740967;
            5'd2:    v = 32'sd919879;
            5'd3:    v = 32'sd466945;
            5'd4:    v = 32'sd234379;
            5'd5:    v = 32'sd117304;
            5'd6:    v = 32'sd58666;
            5'd7:    v = 32'sd29335;
            5'd8:    v = 32'sd14668;
            5'd9:    v = 32'sd7334;
            5'd10:   v = 32'sd3667;
            5'd11:   v = 32'sd1833;
            5'd12:   v = 32'sd917;
            5'd13:   v = 32'sd458;
            5'd14:   v = 32'sd229;
            5'd15:   v = 32'sd115;
            5'd16:   v = 32'sd57;
            5'd17:   v = 32'sd29;
            5'd18:   v = 32'sd14;
            5'd19:   v = 32'sd7;
            5'd20:   v = 32'sd4;
            5'd21:   v = 32'sd2;
            5'd22:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > ANGLE_LIM) begin
            r = ANGLE_LIM;
        end else if (v < -ANGLE_LIM) begin
            r = -ANGLE_LIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // degrees * 2^16 to hundredths of a degree, half away from zero
    function automatic logic [15:0] to_hundredths(input logic signed [ANG_W-1:0] v);
        logic [ANG_W-1:0] mag;
        logic [39:0]      p;
        logic [15:0]      q;
        mag = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
        p   = 40'(mag) * 40'd100 + 40'(1 << (ANGLE_FRAC_BITS - 1));
        q   = p[ANGLE_FRAC_BITS +: 16];
        return v[ANG_W-1] ? 16'(-q) : q;
    endfunction

endpackage

// ----- hw/rtl/itcf_in_if.sv -----
// Sample channel of the IMU tilt filter: valid/ready and one IMU sample.
// Depends on itcf_pkg.
interface itcf_in_if;
    import itcf_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic        [15:0] period;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, period,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, period,
                    output ready);
endinterface

// ----- hw/rtl/itcf_out_if.sv -----
// Result channel of the IMU tilt filter: valid/ready and the fused angles.
// Depends on itcf_pkg.
interface itcf_out_if;
    import itcf_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_out;
    logic signed [15:0] roll_out;

    modport source (output valid, pitch_out, roll_out, input ready);
    modport sink   (input valid, pitch_out, roll_out, output ready);
endinterface

// ----- hw/rtl/itcf_ctrl.sv -----
// Sequencer of the IMU tilt filter: steps the datapath through one request.
// Depends on itcf_pkg.
module itcf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  itcf_pkg::t_stat i_stat,
    output itcf_pkg::t_cmd  o_cmd,
    output logic            o_ready
);
    import itcf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_ITER  = 4'd3;
    localparam logic [3:0] S_CLOAD = 4'd4;
    localparam logic [3:0] S_CORD  = 4'd5;
    localparam logic [3:0] S_M1P   = 4'd6;
    localparam logic [3:0] S_M1S   = 4'd7;
    localparam logic [3:0] S_M2P   = 4'd8;
    localparam logic [3:0] S_M2S   = 4'd9;
    localparam logic [3:0] S_M3P   = 4'd10;
    localparam logic [3:0] S_M3S   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(SQ_STEPS - 1);
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORD_RUN - 1);

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.cidx = r_cnt[CIDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_cnt      = '0;
                n_state    = S_ITER;
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                if (r_cnt == ITER_LAST) begin
                    n_state = S_CLOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CLOAD: begin
                o_cmd.cload = 1'b1;
                n_cnt       = '0;
                n_state     = S_CORD;
            end
            S_CORD: begin
                o_cmd.cstep = 1'b1;
                if (r_cnt == CORD_LAST) begin
                    n_state = S_M1P;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_M1P: begin
                o_cmd.mul  = 1'b1;
                o_cmd.msel = MIX_ACC;
                n_state    = S_M1S;
            end
            S_M1S: begin
                o_cmd.sum  = 1'b1;
                o_cmd.msel = MIX_ACC;
                n_state    = S_M2P;
            end
            S_M2P: begin
                o_cmd.mul  = 1'b1;
                o_cmd.msel = MIX_GYR;
                n_state    = S_M2S;
            end
            S_M2S: begin
                o_cmd.sum  = 1'b1;
                o_cmd.msel = MIX_GYR;
                n_state    = S_M3P;
            end
            S_M3P: begin
                o_cmd.mul  = 1'b1;
                o_cmd.msel = MIX_FUSE;
                n_state    = S_M3S;
            end
            S_M3S: begin
                o_cmd.sum  = 1'b1;
                o_cmd.msel = MIX_FUSE;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_ready = (r_state == S_IDLE);

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_full)
        else $error("result loaded over a waiting result");
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_state == S_PREP))
        else $error("accepted request did not start");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) |-> (r_cnt <= ITER_LAST))
        else $error("iteration count overran");
    a_cord_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORD) |-> (r_cnt <= CORD_LAST))
        else $error("CORDIC step count overran");
`endif
endmodule

// ----- hw/rtl/itcf_dp.sv -----
// Datapath of the IMU tilt filter: square root, CORDIC, gyro increment, blends, state.
// Depends on itcf_pkg; driven by itcf_ctrl.
module itcf_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  itcf_pkg::t_cmd                    i_cmd,
    output itcf_pkg::t_stat                   o_stat,
    input  logic signed [15:0]                i_accel_x,
    input  logic signed [15:0]                i_accel_y,
    input  logic signed [15:0]                i_accel_z,
    input  logic signed [15:0]                i_gyro_x,
    input  logic signed [15:0]                i_gyro_y,
    input  logic        [15:0]                i_period,
    input  logic                              i_cfg_we,
    input  logic        [itcf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [itcf_pkg::W_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [15:0]                o_pitch_out,
    output logic signed [15:0]                o_roll_out
);
    import itcf_pkg::*;

    // configuration
    logic [W_W-1:0] r_accel_blend, r_gyro_blend, r_fusion_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_blend   <= W_W'(6554);
            r_gyro_blend    <= W_W'(65536);
            r_fusion_weight <= W_W'(64225);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ACCEL_BLEND:   r_accel_blend   <= i_cfg_data;
                REG_GYRO_BLEND:    r_gyro_blend    <= i_cfg_data;
                REG_FUSION_WEIGHT: r_fusion_weight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample registers
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy;
    logic        [15:0] r_per;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax  <= i_accel_x;
            r_ay  <= i_accel_y;
            r_az  <= i_accel_z;
            r_gx  <= i_gyro_x;
            r_gy  <= i_gyro_y;
            r_per <= i_period;
        end
    end

    // preparation
    logic signed [15:0]      s_clamp;
    logic signed [31:0]      s_sq;
    logic        [16:0]      gx_abs, gy_abs, az_abs;
    logic signed [16:0]      ay_dir;
    logic        [32:0]      pp_full, pr_full;

    always_comb begin
        if (r_ax > ONE_G) begin
            s_clamp = ONE_G;
        end else if (r_ax < -ONE_G) begin
            s_clamp = -ONE_G;
        end else begin
            s_clamp = r_ax;
        end
        s_sq    = s_clamp * s_clamp;
        gx_abs  = r_gx[15] ? 17'(-{r_gx[15], r_gx}) : {1'b0, r_gx};
        gy_abs  = r_gy[15] ? 17'(-{r_gy[15], r_gy}) : {1'b0, r_gy};
        az_abs  = r_az[15] ? 17'(-{r_az[15], r_az}) : {1'b0, r_az};
        ay_dir  = r_az[15] ? 17'(-{r_ay[15], r_ay}) : {r_ay[15], r_ay};
        pp_full = gy_abs * {1'b0, r_per};
        pr_full = gx_abs * {1'b0, r_per};
    end

    logic        [28:0]      r_s2;
    logic signed [ANG_W-1:0] r_ys;
    logic        [30:0]      r_pp, r_pr;
    logic                    r_az0;
    logic signed [ANG_W-1:0] r_px, r_py, r_pz, r_rx, r_ry, r_rz;

    // square root registers and gyro increments
    logic [SQ_W-1:0]  r_sn, r_sr, r_sb;
    logic [GQ_W-1:0]  r_pq, r_rq;

    // square root step
    logic [SQ_W-1:0] sq_t;
    logic            sq_ge;
    // gyro increment by reciprocal multiply
    logic [30:0]     pg_num, rg_num;
    logic [62:0]     pg_prod, rg_prod;

    always_comb begin
        sq_t    = r_sr + r_sb;
        sq_ge   = (r_sn >= sq_t);
        pg_num  = r_pp + GYRO_HALF;
        rg_num  = r_pr + GYRO_HALF;
        pg_prod = 63'(pg_num) * 63'(GYRO_RECIP);
        rg_prod = 63'(rg_num) * 63'(GYRO_RECIP);
    end

    // CORDIC steps
    logic signed [ANG_W-1:0] c_ang;
    logic signed [ANG_W-1:0] pxs, pys, rxs, rys;

    always_comb begin
        c_ang = atan_step(i_cmd.cidx);
        pxs   = r_px >>> i_cmd.cidx;
        pys   = r_py >>> i_cmd.cidx;
        rxs   = r_rx >>> i_cmd.cidx;
        rys   = r_ry >>> i_cmd.cidx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_s2  <= s_sq[28:0];
            r_ys  <= {{4{s_clamp[15]}}, s_clamp, 12'b0};
            r_pp  <= pp_full[30:0];
            r_pr  <= pr_full[30:0];
            r_az0 <= (r_az == 16'sd0);
            r_rx  <= {3'b0, az_abs, 12'b0};
            r_ry  <= {{3{ay_dir[16]}}, ay_dir, 12'b0};
        end
        if (i_cmd.init) begin
            r_sn <= (SQ_W'(1) << (SQ_W - 1)) - {r_s2, 24'b0};
            r_sr <= '0;
            r_sb <= SQ_W'(1) << (SQ_W - 1);
            r_pq <= pg_prod[GYRO_SHIFT +: GQ_W];
            r_rq <= rg_prod[GYRO_SHIFT +: GQ_W];
        end
        if (i_cmd.iter) begin
            // the root holds once its bit weight has shifted out
            if (r_sb != '0) begin
                if (sq_ge) begin
                    r_sn <= r_sn - sq_t;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
        end
        if (i_cmd.cload) begin
            r_px <= {5'b0, r_sr[26:0]};
            r_py <= r_ys;
            r_pz <= '0;
            r_rz <= '0;
        end
        if (i_cmd.cstep) begin
            if (r_py > 0) begin
                r_px <= r_px + pys;
                r_py <= r_py - pxs;
                r_pz <= r_pz + c_ang;
            end else begin
                r_px <= r_px - pys;
                r_py <= r_py + pxs;
                r_pz <= r_pz - c_ang;
            end
            if (r_ry > 0) begin
                r_rx <= r_rx + rys;
                r_ry <= r_ry - rxs;
                r_rz <= r_rz + c_ang;
            end else begin
                r_rx <= r_rx - rys;
                r_ry <= r_ry + rxs;
                r_rz <= r_rz - c_ang;
            end
        end
    end

    // blends
    logic signed [ANG_W-1:0] r_pest, r_rest, r_pacc, r_racc, r_pgyr, r_rgyr;
    logic signed [ANG_W-1:0] p_delta, r_delta, p_keep, p_take, r_keep, r_take;
    logic        [W_W-1:0]   w_raw, w_sat, w_cmp;
    logic signed [49:0]      r_pma, r_pmb, r_rma, r_rmb;
    logic signed [50:0]      p_sum, r_sum;
    logic signed [ANG_W-1:0] p_res, r_res;

    always_comb begin
        p_delta = r_gy[15] ? -$signed({8'b0, r_pq}) : $signed({8'b0, r_pq});
        r_delta = r_gx[15] ? -$signed({8'b0, r_rq}) : $signed({8'b0, r_rq});
        case (i_cmd.msel)
            MIX_GYR: begin
                p_keep = r_pest;
                p_take = r_pest + p_delta;
                r_keep = r_rest;
                r_take = r_rest + r_delta;
                w_raw  = r_gyro_blend;
            end
            MIX_FUSE: begin
                p_keep = r_pacc;
                p_take = r_pgyr;
                r_keep = r_racc;
                r_take = r_rgyr;
                w_raw  = r_fusion_weight;
            end
            default: begin
                p_keep = r_pest;
                p_take = r_pz;
                r_keep = r_rest;
                r_take = r_rz;
                w_raw  = r_accel_blend;
            end
        endcase
        w_sat = (w_raw > WEIGHT_ONE) ? WEIGHT_ONE : w_raw;
        w_cmp = WEIGHT_ONE - w_sat;
        p_sum = 51'(r_pma) + 51'(r_pmb) + 51'sd32768;
        r_sum = 51'(r_rma) + 51'(r_rmb) + 51'sd32768;
        p_res = p_sum[47:16];
        r_res = r_sum[47:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_pma <= p_keep * $signed({1'b0, w_cmp});
            r_pmb <= p_take * $signed({1'b0, w_sat});
            r_rma <= r_keep * $signed({1'b0, w_cmp});
            r_rmb <= r_take * $signed({1'b0, w_sat});
        end
        if (i_cmd.sum && i_cmd.msel == MIX_ACC) begin
            r_pacc <= p_res;
            r_racc <= r_az0 ? '0 : r_res;
        end
        if (i_cmd.sum && i_cmd.msel == MIX_GYR) begin
            r_pgyr <= p_res;
            r_rgyr <= r_res;
        end
    end

    // estimates and result register
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pest   <= '0;
            r_rest   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.sum && i_cmd.msel == MIX_FUSE) begin
                r_pest <= sat_angle(p_res);
                r_rest <= sat_angle(r_res);
            end
            r_ovalid <= i_cmd.out_load | (r_ovalid & ~i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pitch_out <= to_hundredths(r_pest);
            o_roll_out  <= to_hundredths(r_rest);
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_stat.out_full = r_ovalid & ~i_out_ready;
endmodule

// ----- hw/rtl/imu_tilt_complementary_filter.sv -----
// Top level of the IMU tilt filter: channels, sequencer and datapath.
// Depends on itcf_pkg, itcf_in_if, itcf_out_if, itcf_ctrl and itcf_dp.
// Usage:
//   i_in carries one IMU sample per request; o_out returns one result per
//   sample with fused pitch and roll in hundredths of a degree. Write the
//   three blend weights through i_cfg_we, i_cfg_idx and i_cfg_data only while
//   the block is idle; a write to an index beyond the register list is dropped.
// Sequence:
//   After its sample is accepted, a result passes through preparation (prep,
//   then init, where the gyro increments come out of a reciprocal multiply),
//   27 bit-serial square root steps (the root operand width sets this), a
//   CORDIC load, 16 shared CORDIC steps, three two-stage blends and the load
//   of the result. The block takes one sample at a time: i_in.ready is high
//   only between samples.
// Reset:
//   i_rst_n is synchronous, active low: clear both estimates, load the reset
//   weights and drop any waiting result.
// Stall:
//   Hold a finished result in the output register. The next sample is still
//   accepted and computed; its result holds in the datapath, with i_in.ready
//   low, until the register frees up.
module imu_tilt_complementary_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    itcf_in_if.sink                          i_in,
    itcf_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [itcf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [itcf_pkg::W_W-1:0]         i_cfg_data
);
    import itcf_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  ready;
    logic  accept;

    // request accepted on valid and ready
    assign accept     = i_in.valid & ready;
    assign i_in.ready = ready;

    itcf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_ready  (ready)
    );

    itcf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_accel_x   (i_in.accel_x),
        .i_accel_y   (i_in.accel_y),
        .i_accel_z   (i_in.accel_z),
        .i_gyro_x    (i_in.gyro_x),
        .i_gyro_y    (i_in.gyro_y),
        .i_period    (i_in.period),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_pitch_out (o_out.pitch_out),
        .o_roll_out  (o_out.roll_out)
    );
endmodule
